[hdl/lcm_pkg.sv]
// Shared types, command and status codes for the lock and condition manager.
// No dependencies.
package lcm_pkg;

  localparam int unsigned NumLocksDef   = 16;
  localparam int unsigned NumCondsDef   = 16;
  localparam int unsigned QueueDepthDef = 16;
  localparam int unsigned MaxPairs      = 16;

  typedef enum logic [3:0] {
    CMD_CREATE_LOCK  = 4'd0,
    CMD_DESTROY_LOCK = 4'd1,
    CMD_ACQUIRE      = 4'd2,
    CMD_RELEASE      = 4'd3,
    CMD_CREATE_COND  = 4'd4,
    CMD_DESTROY_COND = 4'd5,
    CMD_WAIT         = 4'd6,
    CMD_SIGNAL       = 4'd7,
    CMD_BROADCAST    = 4'd8
  } cmd_e;

  typedef enum logic [3:0] {
    ST_OK         = 4'd0,
    ST_NO_LOCK    = 4'd1,
    ST_NO_COND    = 4'd2,
    ST_NOT_HELD   = 4'd3,
    ST_WRONG_LOCK = 4'd4,
    ST_DUPLICATE  = 4'd5,
    ST_REL_UNHELD = 4'd6,
    ST_FULL       = 4'd7,
    ST_QUEUE_FULL = 4'd8,
    ST_BAD_CMD    = 4'd9
  } status_e;

  typedef struct packed {
    logic [3:0]  cmd;
    logic [15:0] name_id;
    logic [3:0]  lock_key;
    logic [3:0]  cond_key;
    logic [7:0]  client_machine;
    logic [7:0]  client_process;
    logic [7:0]  client_thread;
  } req_t;

  typedef struct packed {
    logic        send_message;
    logic [7:0]  dest_machine;
    logic [7:0]  dest_process;
    logic [7:0]  dest_thread;
    logic        reply_is_key;
    logic [3:0]  reply_key;
    logic [3:0]  status;
    logic        last;
  } rsp_t;

endpackage

[hdl/lcm_ram.sv]
// Generic single-port-write, single-read RAM with registered read.
// No dependencies.
module lcm_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

[hdl/lock_condition_manager_unit.sv]
// Lock and condition manager, top level: tables, sequencer and queue memories.
// Depends on lcm_pkg and lcm_ram.
//
// One request at a time: busy_o rises on the cycle after start_i is taken and falls at the
// edge that puts the last result beat out, so that beat is shown in the first idle cycle.
// Create first searches the name table entry by entry up to the match, at most NUM_LOCKS or
// NUM_CONDS entries. Destroy, acquire, error results and a release or wait that frees the
// lock give their result directly; a release or wait that hands the lock on first reads the
// waiter memory; signal gives two reply beats; a broadcast does a queue pop and gives two
// reply beats per waiter removed, up to MaxPairs. Each result is shown for one cycle with
// res_valid_o; the receiver cannot stall. Waiters of all locks share one RAM and waiters of
// all conditions another; per-entry tables stay in flip-flops.
module lock_condition_manager_unit
  import lcm_pkg::*;
#(
  parameter int unsigned NUM_LOCKS   = NumLocksDef,
  parameter int unsigned NUM_CONDS   = NumCondsDef,
  parameter int unsigned QUEUE_DEPTH = QueueDepthDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  input  req_t req_i,
  output logic busy_o,
  output logic res_valid_o,
  output rsp_t res_o
);
  localparam int unsigned LW = (NUM_LOCKS > 1) ? $clog2(NUM_LOCKS) : 1;
  localparam int unsigned CW = (NUM_CONDS > 1) ? $clog2(NUM_CONDS) : 1;
  localparam int unsigned QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned NW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned LKW = $clog2(NUM_LOCKS + 1);
  localparam int unsigned CKW = $clog2(NUM_CONDS + 1);
  localparam int unsigned LAW = LW + QW;
  localparam int unsigned CAW = CW + QW;
  localparam int unsigned SW  = (NUM_LOCKS > NUM_CONDS) ? LKW : CKW;

  localparam logic [3:0] S_IDLE = 4'd0, S_SRCH = 4'd1, S_EXEC = 4'd2, S_RD = 4'd3,
                         S_RDW = 4'd4, S_HAND = 4'd5, S_PAIR1 = 4'd6, S_PAIR2 = 4'd7,
                         S_EMIT = 4'd8, S_BPOP = 4'd9;

  logic [3:0] state_q, state_d;
  req_t r_q;

  logic                lv_q [NUM_LOCKS];
  logic                lh_q [NUM_LOCKS];
  logic [15:0]         ln_q [NUM_LOCKS];
  logic [23:0]         lhd_q [NUM_LOCKS];
  logic [QW-1:0]       lqh_q [NUM_LOCKS];
  logic [NW-1:0]       lqc_q [NUM_LOCKS];
  logic                cv_q [NUM_CONDS];
  logic [15:0]         cn_q [NUM_CONDS];
  logic [LKW-1:0]      cb_q [NUM_CONDS];
  logic [QW-1:0]       cqh_q [NUM_CONDS];
  logic [NW-1:0]       cqc_q [NUM_CONDS];
  logic [LKW-1:0]      nkl_q;
  logic [CKW-1:0]      nkc_q;

  logic [SW-1:0] si_q;
  logic          found_q;
  logic [SW-1:0] fkey_q;
  logic [4:0]    pairs_q;
  rsp_t          out_q;
  logic          ov_q;

  logic          lwe, cwe;
  logic [LAW-1:0] lwa, lra;
  logic [CAW-1:0] cwa, cra;
  logic [23:0]   lwd, cwd, lrd, crd;

  lcm_ram #(.Width(24), .Depth(2 ** LAW)) u_lock_q (
    .clk_i, .we_i(lwe), .waddr_i(lwa), .wdata_i(lwd), .raddr_i(lra), .rdata_o(lrd));
  lcm_ram #(.Width(24), .Depth(2 ** CAW)) u_cond_q (
    .clk_i, .we_i(cwe), .waddr_i(cwa), .wdata_i(cwd), .raddr_i(cra), .rdata_o(crd));

  logic [23:0] who;
  logic [LW-1:0] lk;
  logic [CW-1:0] ck;
  logic lok, cok, lin, cin;
  assign who = {r_q.client_machine, r_q.client_process, r_q.client_thread};
  assign lk  = LW'(r_q.lock_key);
  assign ck  = CW'(r_q.cond_key);
  assign lin = 32'(r_q.lock_key) < NUM_LOCKS;
  assign cin = 32'(r_q.cond_key) < NUM_CONDS;
  assign lok = lin && lv_q[lk];
  assign cok = cin && cv_q[ck];

  function automatic logic [QW-1:0] qadd(logic [QW-1:0] h, logic [NW-1:0] c);
    logic [NW:0] s;
    s = (NW+1)'(h) + (NW+1)'(c);
    if (s >= (NW+1)'(QUEUE_DEPTH)) s = s - (NW+1)'(QUEUE_DEPTH);
    return QW'(s);
  endfunction

  assign lra = {lk, lqh_q[lk]};
  assign cra = {ck, cqh_q[ck]};

  logic srch_lock, hit, srch_end;
  logic [SW-1:0] ssize;
  assign srch_lock = (r_q.cmd == CMD_CREATE_LOCK);
  assign ssize = srch_lock ? SW'(NUM_LOCKS) : SW'(NUM_CONDS);
  always_comb begin
    hit = 1'b0;
    if (srch_lock) begin
      if (32'(si_q) < NUM_LOCKS)
        hit = lv_q[LW'(si_q)] && ln_q[LW'(si_q)] == r_q.name_id;
    end else begin
      if (32'(si_q) < NUM_CONDS)
        hit = cv_q[CW'(si_q)] && cn_q[CW'(si_q)] == r_q.name_id;
    end
  end
  assign srch_end = hit || (si_q == ssize - SW'(1));

  function automatic rsp_t mk(logic s, logic [23:0] w, logic k, logic [3:0] key,
                              status_e st);
    rsp_t o;
    o.send_message = s;
    o.dest_machine = w[23:16];
    o.dest_process = w[15:8];
    o.dest_thread  = w[7:0];
    o.reply_is_key = k;
    o.reply_key    = key;
    o.status       = st;
    o.last         = 1'b1;
    return o;
  endfunction

  function automatic rsp_t mk_mid(logic [23:0] w);
    rsp_t o;
    o = mk(1'b1, w, 1'b0, 4'd0, ST_OK);
    o.last = 1'b0;
    return o;
  endfunction

  assign busy_o      = (state_q != S_IDLE);
  assign res_valid_o = ov_q;
  assign res_o       = out_q;

  logic [LKW-1:0] cbl;
  assign cbl = cb_q[ck];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ov_q    <= 1'b0;
      nkl_q   <= '0;
      nkc_q   <= '0;
      for (int i = 0; i < NUM_LOCKS; i++) begin
        lv_q[i] <= 1'b0; lh_q[i] <= 1'b0; lqh_q[i] <= '0; lqc_q[i] <= '0;
      end
      for (int i = 0; i < NUM_CONDS; i++) begin
        cv_q[i] <= 1'b0; cb_q[i] <= LKW'(NUM_LOCKS); cqh_q[i] <= '0; cqc_q[i] <= '0;
      end
    end else begin
      ov_q <= (state_q == S_PAIR1) || (state_q == S_PAIR2) || (state_q == S_EMIT);
      case (state_q)
        S_IDLE: begin
          if (start_i) begin
            r_q     <= req_i;
            si_q    <= '0;
            found_q <= 1'b0;
            pairs_q <= '0;
            state_q <= (req_i.cmd == CMD_CREATE_LOCK || req_i.cmd == CMD_CREATE_COND)
                       ? S_SRCH : S_EXEC;
          end
        end
        S_SRCH: begin
          si_q <= si_q + SW'(1);
          if (hit) begin
            found_q <= 1'b1;
            fkey_q  <= si_q;
          end
          if (srch_end) state_q <= S_EXEC;
        end
        S_EXEC: begin
          case (r_q.cmd)
            CMD_CREATE_LOCK: begin
              state_q <= S_EMIT;
              if (found_q) out_q <= mk(1'b1, who, 1'b1, 4'(fkey_q), ST_OK);
              else if (32'(nkl_q) >= NUM_LOCKS) out_q <= mk(1'b0, who, 1'b0, 4'd0, ST_FULL);
              else begin
                lv_q[LW'(nkl_q)] <= 1'b1; ln_q[LW'(nkl_q)] <= r_q.name_id;
                lh_q[LW'(nkl_q)] <= 1'b0; lqh_q[LW'(nkl_q)] <= '0; lqc_q[LW'(nkl_q)] <= '0;
                nkl_q <= nkl_q + LKW'(1);
                out_q <= mk(1'b1, who, 1'b1, 4'(nkl_q), ST_OK);
              end
            end
            CMD_CREATE_COND: begin
              state_q <= S_EMIT;
              if (found_q) out_q <= mk(1'b1, who, 1'b1, 4'(fkey_q), ST_OK);
              else if (32'(nkc_q) >= NUM_CONDS) out_q <= mk(1'b0, who, 1'b0, 4'd0, ST_FULL);
              else begin
                cv_q[CW'(nkc_q)] <= 1'b1; cn_q[CW'(nkc_q)] <= r_q.name_id;
                cb_q[CW'(nkc_q)] <= LKW'(NUM_LOCKS);
                cqh_q[CW'(nkc_q)] <= '0; cqc_q[CW'(nkc_q)] <= '0;
                nkc_q <= nkc_q + CKW'(1);
                out_q <= mk(1'b1, who, 1'b1, 4'(nkc_q), ST_OK);
              end
            end
            CMD_DESTROY_LOCK: begin
              state_q <= S_EMIT;
              if (!lok) out_q <= mk(1'b0, who, 1'b0, 4'd0, ST_NO_LOCK);
              else begin
                lv_q[lk] <= 1'b0; lh_q[lk] <= 1'b0; lqh_q[lk] <= '0; lqc_q[lk] <= '0;
                out_q <= mk(1'b0, who, 1'b0, 4'd0, ST_OK);
              end
            end
            CMD_DESTROY_COND: begin
              state_q <= S_EMIT;
              if (!cok) out_q <= mk(1'b0, who, 1'b0, 4'd0, ST_NO_COND);
              else begin
                cv_q[ck] <= 1'b0; cb_q[ck] <= LKW'(NUM_LOCKS);
                cqh_q[ck] <= '0; cqc_q[ck] <= '0;
                out_q <= mk(1'b0, who, 1'b0, 4'd0, ST_OK);
              end
            end
            CMD_ACQUIRE: begin
              state_q <= S_EMIT;
              if (!lok) out_q <= mk(1'b0, who, 1'b0, 4'd0, ST_NO_LOCK);
              else if (!lh_q[lk]) begin
                lh_q[lk] <= 1'b1; lhd_q[lk] <= who;
                out_q <= mk(1'b1, who, 1'b0, 4'd0, ST_OK);
              end else if (lhd_q[lk] == who)
                out_q <= mk(1'b0, who, 1'b0, 4'd0, ST_DUPLICATE);
              else if (32'(lqc_q[lk]) >= QUEUE_DEPTH)
                out_q <= mk(1'b0, who, 1'b0, 4'd0, ST_QUEUE_FULL);
              else begin
                lqc_q[lk] <= lqc_q[lk] + NW'(1);
                out_q <= mk(1'b0, who, 1'b0, 4'd0, ST_OK);
              end
            end
            CMD_RELEASE: begin
              if (!lok) begin
                out_q   <= mk(1'b0, who, 1'b0, 4'd0, ST_NO_LOCK);
                state_q <= S_EMIT;
              end else if (!lh_q[lk] || lhd_q[lk] != who) begin
                out_q   <= mk(1'b0, who, 1'b0, 4'd0, ST_REL_UNHELD);
                state_q <= S_EMIT;
              end else if (lqc_q[lk] == '0) begin
                lh_q[lk] <= 1'b0;
                out_q    <= mk(1'b0, who, 1'b0, 4'd0, ST_OK);
                state_q  <= S_EMIT;
              end else state_q <= S_RD;
            end
            CMD_WAIT, CMD_SIGNAL, CMD_BROADCAST: begin
              if (!cok) begin
                out_q   <= mk(1'b0, who, 1'b0, 4'd0, ST_NO_COND);
                state_q <= S_EMIT;
              end else if (!lok) begin
                out_q   <= mk(1'b0, who, 1'b0, 4'd0, ST_NO_LOCK);
                state_q <= S_EMIT;
              end else if (!lh_q[lk] || lhd_q[lk] != who) begin
                out_q   <= mk(1'b0, who, 1'b0, 4'd0, ST_NOT_HELD);
                state_q <= S_EMIT;
              end else if (r_q.cmd == CMD_WAIT) begin
                if (cbl != LKW'(NUM_LOCKS) && cbl != LKW'(lk)) begin
                  out_q   <= mk(1'b0, who, 1'b0, 4'd0, ST_WRONG_LOCK);
                  state_q <= S_EMIT;
                end else if (32'(cqc_q[ck]) >= QUEUE_DEPTH) begin
                  out_q   <= mk(1'b0, who, 1'b0, 4'd0, ST_QUEUE_FULL);
                  state_q <= S_EMIT;
                end else begin
                  cqc_q[ck] <= cqc_q[ck] + NW'(1);
                  cb_q[ck]  <= LKW'(lk);
                  if (lqc_q[lk] == '0) begin
                    lh_q[lk] <= 1'b0;
                    out_q    <= mk(1'b0, who, 1'b0, 4'd0, ST_OK);
                    state_q  <= S_EMIT;
                  end else state_q <= S_RD;
                end
              end else if (cbl != LKW'(lk)) begin
                out_q   <= mk(1'b0, who, 1'b0, 4'd0, ST_WRONG_LOCK);
                state_q <= S_EMIT;
              end else if (r_q.cmd == CMD_SIGNAL) begin
                if (cqc_q[ck] != '0) begin
                  cqh_q[ck] <= qadd(cqh_q[ck], NW'(1));
                  cqc_q[ck] <= cqc_q[ck] - NW'(1);
                end
                state_q <= S_PAIR1;
              end else if (cqc_q[ck] != '0) state_q <= S_BPOP;
              else begin
                out_q   <= mk(1'b0, who, 1'b0, 4'd0, ST_OK);
                state_q <= S_EMIT;
              end
            end
            default: begin
              out_q   <= mk(1'b0, who, 1'b0, 4'd0, ST_BAD_CMD);
              state_q <= S_EMIT;
            end
          endcase
        end
        S_RD: state_q <= S_RDW;
        S_RDW: begin
          lhd_q[lk] <= lrd;
          lqh_q[lk] <= qadd(lqh_q[lk], NW'(1));
          lqc_q[lk] <= lqc_q[lk] - NW'(1);
          out_q   <= mk(1'b1, lrd, 1'b0, 4'd0, ST_OK);
          state_q <= S_EMIT;
        end
        S_BPOP: begin
          cqh_q[ck] <= qadd(cqh_q[ck], NW'(1));
          cqc_q[ck] <= cqc_q[ck] - NW'(1);
          pairs_q   <= pairs_q + 5'd1;
          state_q   <= S_PAIR1;
        end
        S_PAIR1: begin
          out_q   <= mk_mid(who);
          state_q <= S_PAIR2;
        end
        S_PAIR2: begin
          if (r_q.cmd == CMD_BROADCAST && cqc_q[ck] != '0 && 32'(pairs_q) < MaxPairs) begin
            out_q   <= mk_mid(who);
            state_q <= S_BPOP;
          end else begin
            out_q   <= mk(1'b1, who, 1'b0, 4'd0, ST_OK);
            state_q <= S_IDLE;
          end
        end
        S_EMIT: begin
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    lwe = 1'b0;
    lwa = {lk, qadd(lqh_q[lk], lqc_q[lk])};
    lwd = who;
    cwe = 1'b0;
    cwa = {ck, qadd(cqh_q[ck], cqc_q[ck])};
    cwd = who;
    if (state_q == S_EXEC && r_q.cmd == CMD_ACQUIRE && lok && lh_q[lk] &&
        lhd_q[lk] != who && 32'(lqc_q[lk]) < QUEUE_DEPTH) lwe = 1'b1;
    if (state_q == S_EXEC && r_q.cmd == CMD_WAIT && cok && lok && lh_q[lk] &&
        lhd_q[lk] == who && (cbl == LKW'(NUM_LOCKS) || cbl == LKW'(lk)) &&
        32'(cqc_q[ck]) < QUEUE_DEPTH) cwe = 1'b1;
  end

  logic unused_crd;
  assign unused_crd = ^{crd, cra};
endmodule
